// ===== hdl/frim_pkg.sv =====
// Package for the frame ring index engine: codes, slot entry layout and defaults.
// Used by the core, the checker and the testbench; depends on nothing.
package frim_pkg;

  localparam int unsigned DefSlots   = 1024;
  localparam int unsigned DefReaders = 8;
  localparam int unsigned VideoHdrBytes = 32;
  localparam int unsigned AudioHdrBytes = 16;
  localparam logic [31:0] BufSizeReset  = 32'd4194304;
  localparam logic [31:0] AlignLow      = 32'd7;

  typedef enum logic [1:0] {
    FN_PUT  = 2'd0,
    FN_GET  = 2'd1,
    FN_RST  = 2'd2,
    FN_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_P = 2'd0,
    KIND_I = 2'd1,
    KIND_A = 2'd2,
    KIND_X = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD       = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_EMPTY_LAP = 3'd3,
    STS_OVERRUN   = 3'd4,
    STS_FAR       = 3'd5
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [31:0] start;
    logic [24:0] len;
    logic [63:0] stamp;
    logic [1:0]  kind;
    logic        talk;
  } slot_entry_t;

endpackage

// ===== hdl/frim_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module frim_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/frame_ring_index_multi_reader_core.sv =====
// Top level of the frame ring index engine: writer state, reader state, sequencer.
// Depends on frim_pkg and frim_ram.

// Each request has a transfer cycle, in which a get presents its slot
// address to the slot table RAM, and an execute state, in which the
// registered RAM word is used, the state is updated and a put writes its
// slot entry back; the execute state waits while a result is still unread.
// A new request is taken once the execute cycle has finished; the result sits
// in an output register, so the next request is taken while it waits. The
// slot table is not cleared after reset; a reader must not read a slot that
// was never written. Configuration writes are taken in any cycle.
module frame_ring_index_multi_reader_core #(
  parameter int unsigned SLOTS   = frim_pkg::DefSlots,
  parameter int unsigned READERS = frim_pkg::DefReaders
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [23:0] frame_len_i,
  input  logic [1:0]  frame_kind_i,
  input  logic        talk_flag_i,
  input  logic [63:0] stamp_in_i,
  input  logic [3:0]  reader_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] start_pos_o,
  output logic [24:0] entry_len_o,
  output logic [63:0] stamp_out_o,
  output logic [1:0]  kind_out_o,
  output logic        talk_out_o,
  output logic [31:0] key_offset_o,
  output logic [10:0] lag_o
);
  import frim_pkg::*;

  localparam int unsigned AW  = $clog2(SLOTS);
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned RIW = (READERS > 1) ? $clog2(READERS) : 1;

  // Configuration register: always ready.
  logic [31:0] buf_size_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= BufSizeReset;
    end else if (cfg_valid_i) begin
      buf_size_q <= cfg_data_i;
    end
  end

  // Writer state.
  logic [31:0]   wp_q, wp_d;
  logic [CW-1:0] sn_q, sn_d;
  logic [CW-1:0] su_q, su_d;
  logic [31:0]   lap_q, lap_d;
  logic [AW-1:0] lks_q, lks_d;
  logic [31:0]   krun_q, krun_d;

  // Reader state, one register set per reader.
  logic [CW-1:0] rd_slot_q [READERS];
  logic [31:0]   rd_lap_q  [READERS];
  logic [10:0]   rd_lag_q  [READERS];

  // Sequencer.
  state_e state_q, state_d;
  logic   in_fire, exec_fire;

  // Request latched at its transfer.
  func_e          func_q;
  logic [23:0]    len_q;
  kind_e          kind_q;
  logic           talk_q;
  logic [63:0]    stamp_q;
  logic [RIW-1:0] rid_q;
  logic           bad_q;
  logic [CW-1:0]  rs1_q;
  logic [31:0]    rl1_q;
  status_e        st1_q;
  logic           inrng_q;

  // Output register.
  logic        out_valid_q;
  status_e     status_q;
  logic [31:0] start_q;
  logic [24:0] elen_q;
  logic [63:0] stamp_out_q;
  logic [1:0]  kind_out_q;
  logic        talk_out_q;
  logic [31:0] koff_q;
  logic [10:0] lag_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign exec_fire  = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Front end of a get: the first position decision only needs the reader
  // registers, so it is made in the transfer cycle and picks the RAM address.
  logic [RIW-1:0] rid;
  logic           bad;
  logic [CW-1:0]  rs0, rs1;
  logic [31:0]    rl0, rl1;
  status_e        st1;

  assign rid = reader_i[RIW-1:0];
  assign bad = ({1'b0, reader_i} >= 5'(READERS));
  assign rs0 = rd_slot_q[rid];
  assign rl0 = rd_lap_q[rid];

  always_comb begin
    rs1 = rs0;
    rl1 = rl0;
    st1 = STS_OK;
    if (rs0 == sn_q && rl0 == lap_q) begin
      st1 = STS_EMPTY;
    end else if (rs0 >= su_q && rl0 < lap_q) begin
      // The writer wrapped since this reader's lap: restart at slot zero.
      rs1 = '0;
      rl1 = lap_q;
      if (sn_q == '0) begin
        st1 = STS_EMPTY_LAP;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q  <= func_e'(func_i);
      len_q   <= frame_len_i;
      kind_q  <= kind_e'(frame_kind_i);
      talk_q  <= talk_flag_i;
      stamp_q <= stamp_in_i;
      rid_q   <= rid;
      bad_q   <= bad;
      rs1_q   <= rs1;
      rl1_q   <= rl1;
      st1_q   <= st1;
      inrng_q <= (rs1 < CW'(SLOTS));
    end
  end

  // Slot table.
  slot_entry_t wr_ent, rd_raw, rd_ent;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr;

  assign ram_re = in_fire && (func_i == FN_GET);

  frim_ram #(
    .Width ($bits(slot_entry_t)),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (rs1[AW-1:0]),
    .rdata_o (rd_raw)
  );

  // A reader parked at the end of the table sees an all-zero entry.
  assign rd_ent = inrng_q ? rd_raw : '0;

  // Put path.
  kind_e         kind_n;
  logic [24:0]   elen;
  logic [31:0]   space, wp0, aligned, wp1;
  logic          wrap;
  logic [CW-1:0] sn0, su0, sn1, su1;
  logic [31:0]   lap0;

  always_comb begin
    kind_n  = (kind_q == KIND_X) ? KIND_P : kind_q;
    elen    = 25'(len_q) + ((kind_n == KIND_A) ? 25'(AudioHdrBytes) : 25'(VideoHdrBytes));
    space   = (wp_q >= buf_size_q) ? 32'd0 : (buf_size_q - wp_q);
    wrap    = (32'(elen) > space);
    sn0     = wrap ? '0 : sn_q;
    su0     = wrap ? sn_q : su_q;
    lap0    = lap_q + 32'(wrap);
    wp0     = wrap ? 32'd0 : wp_q;
    aligned = (32'(elen) + AlignLow) & ~AlignLow;
    wp1     = (wp0 + 32'(elen) + AlignLow) & ~AlignLow;
    sn1     = sn0 + CW'(1);
    su1     = (sn1 > su0) ? sn1 : su0;
    wr_ent.start = wp0;
    wr_ent.len   = elen;
    wr_ent.stamp = stamp_q;
    wr_ent.kind  = kind_n;
    wr_ent.talk  = (kind_n == KIND_A) ? talk_q : 1'b0;
  end

  assign ram_we    = exec_fire && (func_q == FN_PUT);
  assign ram_waddr = sn0[AW-1:0];

  // Get path, second half: overrun check against the entry just read.
  logic [31:0]   ldiff;
  status_e       st2;
  logic [CW-1:0] rs2, rs3;
  logic [31:0]   rl2;
  logic [CW:0]   tot, lag_raw;
  logic          lag_upd;
  logic [10:0]   lag_old, lag_new;

  always_comb begin
    ldiff   = lap_q - rl1_q;
    st2     = st1_q;
    rs2     = rs1_q;
    rl2     = rl1_q;
    if (st1_q == STS_OK) begin
      if (ldiff == 32'd1 && rd_ent.start < wp_q) begin
        st2 = STS_OVERRUN;
        rs2 = CW'(lks_q);
        rl2 = lap_q;
      end else if (ldiff >= 32'd2) begin
        st2 = STS_FAR;
        rs2 = CW'(lks_q);
        rl2 = lap_q;
      end
    end
    rs3 = (rs2 < CW'(SLOTS)) ? (rs2 + CW'(1)) : rs2;
    tot = {1'b0, su_q} + {1'b0, sn_q};
    lag_raw = '0;
    lag_upd = 1'b0;
    if (rs3 < sn_q && rl2 == lap_q) begin
      lag_raw = {1'b0, sn_q} - {1'b0, rs3};
      lag_upd = 1'b1;
    end else if (rs3 >= sn_q && rl2 < lap_q) begin
      lag_raw = (tot > {1'b0, rs3}) ? (tot - {1'b0, rs3}) : '0;
      lag_upd = 1'b1;
    end
    lag_old = rd_lag_q[rid_q];
    lag_new = lag_old;
    if (lag_upd) begin
      lag_new = (32'(lag_raw) > 32'd2047) ? 11'd2047 : 11'(lag_raw);
    end
  end

  // Writer next state.
  always_comb begin
    wp_d   = wp_q;
    sn_d   = sn_q;
    su_d   = su_q;
    lap_d  = lap_q;
    lks_d  = lks_q;
    krun_d = krun_q;
    if (func_q == FN_PUT) begin
      krun_d = ((kind_n == KIND_I) ? 32'd0 : krun_q) + aligned;
      lks_d  = (kind_n == KIND_I) ? sn0[AW-1:0] : lks_q;
      if (sn1 >= CW'(SLOTS)) begin
        // The slot table is full: the next frame starts a new lap at zero.
        su_d  = CW'(SLOTS);
        sn_d  = '0;
        lap_d = lap0 + 32'd1;
        wp_d  = 32'd0;
      end else begin
        su_d  = su1;
        sn_d  = sn1;
        lap_d = lap0;
        wp_d  = wp1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      sn_q   <= '0;
      su_q   <= '0;
      lap_q  <= '0;
      lks_q  <= '0;
      krun_q <= '0;
    end else if (exec_fire) begin
      wp_q   <= wp_d;
      sn_q   <= sn_d;
      su_q   <= su_d;
      lap_q  <= lap_d;
      lks_q  <= lks_d;
      krun_q <= krun_d;
    end
  end

  // Reader state update for get and reader reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(READERS); i++) begin
        rd_slot_q[i] <= '0;
        rd_lap_q[i]  <= '0;
        rd_lag_q[i]  <= '0;
      end
    end else if (exec_fire && !bad_q) begin
      if (func_q == FN_GET) begin
        rd_slot_q[rid_q] <= (st2 == STS_OK) ? rs3 : rs2;
        rd_lap_q[rid_q]  <= rl2;
        if (st2 == STS_OK) begin
          rd_lag_q[rid_q] <= lag_new;
        end
      end else if (func_q == FN_RST) begin
        rd_slot_q[rid_q] <= CW'(lks_q);
        rd_lap_q[rid_q]  <= (CW'(lks_q) <= sn_q) ? lap_q : (lap_q - 32'd1);
        rd_lag_q[rid_q]  <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= (func_q != FN_NONE);
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      status_q    <= STS_OK;
      start_q     <= '0;
      elen_q      <= '0;
      stamp_out_q <= '0;
      kind_out_q  <= '0;
      talk_out_q  <= 1'b0;
      koff_q      <= '0;
      lag_q       <= '0;
      if (func_q == FN_PUT) begin
        start_q <= wp0;
        elen_q  <= elen;
        koff_q  <= krun_q;
      end else if (bad_q) begin
        status_q <= STS_BAD;
      end else if (func_q == FN_GET) begin
        status_q <= st2;
        if (st2 == STS_OK) begin
          start_q     <= rd_ent.start;
          elen_q      <= rd_ent.len;
          stamp_out_q <= rd_ent.stamp;
          kind_out_q  <= rd_ent.kind;
          talk_out_q  <= rd_ent.talk;
          lag_q       <= lag_new;
        end else begin
          lag_q <= lag_old;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign start_pos_o  = start_q;
  assign entry_len_o  = elen_q;
  assign stamp_out_o  = stamp_out_q;
  assign kind_out_o   = kind_out_q;
  assign talk_out_o   = talk_out_q;
  assign key_offset_o = koff_q;
  assign lag_o        = lag_q;

endmodule

// ===== hdl/frim_checker.sv =====
// Port-level checker for the frame ring index engine, bound to the top level.
// Depends on frim_pkg and frame_ring_index_multi_reader_core.
module frim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] start_pos_o,
  input logic [24:0] entry_len_o,
  input logic [10:0] lag_o
);
  import frim_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken during execute cycle");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STS_FAR)
    else $error("status code out of range");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STS_BAD |-> start_pos_o == '0 && entry_len_o == '0
      && lag_o == '0)
    else $error("bad reader result carries data");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_EMPTY || status_o == STS_EMPTY_LAP)
      |-> start_pos_o == '0 && entry_len_o == '0)
    else $error("empty result carries an entry");

endmodule

bind frame_ring_index_multi_reader_core frim_checker u_frim_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .start_pos_o (start_pos_o),
  .entry_len_o (entry_len_o),
  .lag_o       (lag_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for frame_ring_index_multi_reader_core: a directed table, then
// random put/get/reset traffic, checked against an in-bench model of the ring index.
// Depends on frim_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import frim_pkg::*;

  localparam int unsigned NSLOT = DefSlots;
  localparam int unsigned NRD   = DefReaders;
  localparam int CycleLimit = 400000;

  // One result item as the core presents it.
  typedef struct {
    status_e     status;
    logic [31:0] start;
    logic [24:0] elen;
    logic [63:0] stamp;
    logic [1:0]  kind;
    logic        talk;
    logic [31:0] koff;
    logic [10:0] lag;
  } frame_res_t;

  // One request; typed rows carry a hand-written expectation.
  typedef struct {
    func_e       func;
    logic [23:0] len;
    logic [1:0]  kind;
    logic        talk;
    logic [63:0] stamp;
    logic [3:0]  rdr;
    bit          typed;
    frame_res_t  res;
  } ring_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func_d = '0;
  logic [23:0] len_d = '0;
  logic [1:0]  kind_d = '0;
  logic        talk_d = 1'b0;
  logic [63:0] stamp_d = '0;
  logic [3:0]  rdr_d = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status_q;
  logic [31:0] start_q;
  logic [24:0] elen_q;
  logic [63:0] stamp_q;
  logic [1:0]  kind_q;
  logic        talk_q;
  logic [31:0] koff_q;
  logic [10:0] lag_q;

  always #6 clk = ~clk;

  frame_ring_index_multi_reader_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func_d),
    .frame_len_i  (len_d),
    .frame_kind_i (kind_d),
    .talk_flag_i  (talk_d),
    .stamp_in_i   (stamp_d),
    .reader_i     (rdr_d),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status_q),
    .start_pos_o  (start_q),
    .entry_len_o  (elen_q),
    .stamp_out_o  (stamp_q),
    .kind_out_o   (kind_q),
    .talk_out_o   (talk_q),
    .key_offset_o (koff_q),
    .lag_o        (lag_q)
  );

  // ---------------------------------------------------------------------------
  // Ring index model. Writer state, slot table and per-reader position.
  // ---------------------------------------------------------------------------
  logic [31:0] buf_size;
  logic [31:0] wpos, slot_now, slots_used, lap, key_slot, key_run;
  logic [31:0] tbl_start [NSLOT];
  logic [24:0] tbl_len   [NSLOT];
  logic [63:0] tbl_stamp [NSLOT];
  logic [1:0]  tbl_kind  [NSLOT];
  logic        tbl_talk  [NSLOT];
  bit          written   [NSLOT];
  logic [31:0] rd_slot [NRD];
  logic [31:0] rd_lap  [NRD];
  logic [31:0] rd_lag  [NRD];

  frame_res_t pending_results[$];
  int errors = 0;
  int cycles = 0;

  function automatic frame_res_t zero_res();
    frame_res_t z;
    z = '{STS_OK, '0, '0, '0, '0, 1'b0, '0, '0};
    return z;
  endfunction

  function automatic frame_res_t apply_put(logic [23:0] len, logic [1:0] kind_in,
                                           logic talk, logic [63:0] stamp);
    frame_res_t  r;
    logic [1:0]  k;
    logic [31:0] elen, space, aligned;
    r = zero_res();
    k = (kind_in == KIND_X) ? KIND_P : kind_in;
    elen = {8'd0, len} + ((k == KIND_A) ? AudioHdrBytes : VideoHdrBytes);
    space = (wpos >= buf_size) ? 32'd0 : buf_size - wpos;
    // Not enough room left: wrap to the start of the store, new lap.
    if (space < elen) begin
      slots_used = slot_now;
      slot_now = 0;
      lap = lap + 1;
      wpos = 0;
    end
    tbl_start[slot_now] = wpos;
    tbl_len[slot_now]   = elen[24:0];
    tbl_stamp[slot_now] = stamp;
    tbl_kind[slot_now]  = k;
    tbl_talk[slot_now]  = (k == KIND_A) ? talk : 1'b0;
    written[slot_now]   = 1'b1;
    r.start = wpos;
    r.elen  = elen[24:0];
    r.koff  = key_run;
    aligned = (elen + 32'd7) & ~AlignLow;
    if (k == KIND_I) key_run = 0;
    key_run = key_run + aligned;
    wpos = (wpos + elen + 32'd7) & ~AlignLow;
    if (k == KIND_I) key_slot = slot_now;
    slot_now = slot_now + 1;
    if (slot_now > slots_used) slots_used = slot_now;
    // Slot table full: also a wrap.
    if (slot_now >= NSLOT) begin
      slots_used = slot_now;
      slot_now = 0;
      lap = lap + 1;
      wpos = 0;
    end
    return r;
  endfunction

  // Get for one reader. With commit clear nothing changes; unsafe reports whether
  // the get would touch a slot that was never written.
  function automatic frame_res_t apply_get(int unsigned ri, bit commit, output bit unsafe);
    frame_res_t  r;
    logic [31:0] rs, rl, lagv, tot;
    status_e     st;
    r = zero_res();
    unsafe = 1'b0;
    rs = rd_slot[ri];
    rl = rd_lap[ri];
    lagv = rd_lag[ri];
    st = STS_OK;
    if (rs == slot_now && rl == lap) begin
      st = STS_EMPTY;
    end else begin
      if (rs >= slots_used && rl < lap) begin
        rs = 0;
        rl = lap;
        if (rs == slot_now) st = STS_EMPTY_LAP;
      end
      if (st == STS_OK) begin
        if (lap - rl == 32'd1) begin
          if (rs < NSLOT && !written[rs]) unsafe = 1'b1;
        end
        if (lap - rl == 32'd1 && ((rs < NSLOT) ? tbl_start[rs] : 32'd0) < wpos) begin
          rs = key_slot;
          rl = lap;
          st = STS_OVERRUN;
        end else if (lap - rl >= 32'd2) begin
          rs = key_slot;
          rl = lap;
          st = STS_FAR;
        end
      end
      if (st == STS_OK) begin
        // A position at or past the table end reads as an all-zero entry.
        if (rs < NSLOT) begin
          if (!written[rs]) unsafe = 1'b1;
          r.start = tbl_start[rs];
          r.elen  = tbl_len[rs];
          r.stamp = tbl_stamp[rs];
          r.kind  = tbl_kind[rs];
          r.talk  = tbl_talk[rs];
          rs = rs + 1;
        end
        if (rs < slot_now && rl == lap) begin
          lagv = slot_now - rs;
        end else if (rs >= slot_now && rl < lap) begin
          tot = slots_used + slot_now;
          lagv = (tot > rs) ? tot - rs : 32'd0;
        end
        if (lagv > 32'd2047) lagv = 32'd2047;
      end
    end
    r.status = st;
    r.lag = lagv[10:0];
    if (commit) begin
      rd_slot[ri] = rs;
      rd_lap[ri]  = rl;
      rd_lag[ri]  = lagv;
    end
    return r;
  endfunction

  // Returns 1 when the request produces a result.
  function automatic bit apply_request(ring_req_t q, output frame_res_t r);
    bit dummy;
    r = zero_res();
    if (q.func == FN_NONE) return 1'b0;
    if (q.func == FN_PUT) begin
      r = apply_put(q.len, q.kind, q.talk, q.stamp);
    end else if (q.rdr >= NRD) begin
      r.status = STS_BAD;
    end else if (q.func == FN_GET) begin
      r = apply_get(q.rdr, 1'b1, dummy);
    end else begin
      // Reader reset: park the reader on the latest key frame.
      rd_lap[q.rdr]  = (key_slot <= slot_now) ? lap : lap - 32'd1;
      rd_slot[q.rdr] = key_slot;
      rd_lag[q.rdr]  = 0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. Prediction is done in the sending process at the transfer edge, so
  // the model is current when the next request is chosen.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit gaps_on = 1'b1;

  task automatic send_req(ring_req_t q);
    frame_res_t r;
    bit unsafe;
    int gap;
    // A get that would land on a slot never written is turned into a put.
    if (q.func == FN_GET && q.rdr < NRD) begin
      r = apply_get(q.rdr, 1'b0, unsafe);
      if (unsafe) begin
        q.func = FN_PUT;
        q.typed = 1'b0;
      end
    end
    in_valid <= 1'b1;
    func_d   <= q.func;
    len_d    <= q.len;
    kind_d   <= q.kind;
    talk_d   <= q.talk;
    stamp_d  <= q.stamp;
    rdr_d    <= q.rdr;
    do @(posedge clk); while (!in_ready);
    if (apply_request(q, r)) pending_results.push_back(q.typed ? q.res : r);
    // Bursts of requests held valid without a break, separated by idle gaps.
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every expected result has arrived, then idles on in case
  // the core is still busy with a request that gives no result.
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_buf_size(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    buf_size = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_len(logic [31:0] bsz);
    int unsigned sel, lim;
    sel = $urandom_range(0, 99);
    if (sel < 4) return $urandom;
    if (sel < 8) return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h0;
    lim = (bsz > 2048) ? 2048 : bsz;
    if (bsz == 32'hFFFFFFFF) lim = 300;
    return $urandom_range(0, lim);
  endfunction

  task automatic random_phase(logic [31:0] bsz, int n_items, int put_pct);
    ring_req_t q;
    int sel;
    for (int i = 0; i < n_items; i++) begin
      q.len   = pick_len(bsz);
      q.kind  = $urandom_range(0, 3);
      q.talk  = $urandom_range(0, 1);
      q.stamp = {$urandom, $urandom};
      q.rdr   = ($urandom_range(0, 9) == 0) ? $urandom_range(NRD, 15)
                                            : $urandom_range(0, NRD - 1);
      q.typed = 1'b0;
      q.res   = zero_res();
      sel = $urandom_range(0, 99);
      if (sel < put_pct) q.func = FN_PUT;
      else if (sel < put_pct + (100 - put_pct) * 3 / 4) q.func = FN_GET;
      else if (sel < 97) q.func = FN_RST;
      else q.func = FN_NONE;
      send_req(q);
    end
  endtask

  // Directed rows. The typed ones are fixed values visible without the model:
  // state right after reset, the first put, and gets and resets of bad readers.
  ring_req_t dir_rows[$];

  initial begin
    frame_res_t z, bad;
    z = zero_res();
    bad = zero_res();
    bad.status = STS_BAD;
    buf_size = BufSizeReset;
    wpos = 0; slot_now = 0; slots_used = 0; lap = 0; key_slot = 0; key_run = 0;
    for (int i = 0; i < NSLOT; i++) written[i] = 1'b0;
    for (int i = 0; i < NRD; i++) begin
      rd_slot[i] = 0; rd_lap[i] = 0; rd_lag[i] = 0;
    end

    // Empty reader after reset, bad readers at both ends of the illegal range.
    dir_rows.push_back('{FN_GET, 24'd0, KIND_P, 1'b0, 64'd0, 4'd0, 1'b1,
                         '{STS_EMPTY, '0, '0, '0, '0, 1'b0, '0, '0}});
    dir_rows.push_back('{FN_GET, 24'd0, KIND_P, 1'b0, 64'd0, 4'd8, 1'b1, bad});
    dir_rows.push_back('{FN_RST, 24'd0, KIND_P, 1'b0, 64'd0, 4'd15, 1'b1, bad});
    // First put lands at zero with a 32-byte video header.
    dir_rows.push_back('{FN_PUT, 24'd0, KIND_P, 1'b0, 64'd0, 4'd0, 1'b1,
                         '{STS_OK, '0, 25'd32, '0, '0, 1'b0, '0, '0}});
    // Frame larger than the store, then puts that must wrap; kind 3 and video talk.
    dir_rows.push_back('{FN_PUT, 24'hFFFFFF, KIND_I, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                         4'd0, 1'b0, z});
    dir_rows.push_back('{FN_PUT, 24'd100, KIND_A, 1'b1, 64'h1234, 4'd0, 1'b0, z});
    dir_rows.push_back('{FN_PUT, 24'd5, KIND_X, 1'b1, 64'h5, 4'd0, 1'b0, z});
    dir_rows.push_back('{FN_GET, 24'd0, KIND_P, 1'b0, 64'd0, 4'd0, 1'b0, z});
    dir_rows.push_back('{FN_NONE, 24'd7, KIND_I, 1'b1, 64'd9, 4'd2, 1'b0, z});
    dir_rows.push_back('{FN_RST, 24'd0, KIND_P, 1'b0, 64'd0, 4'd0, 1'b0, z});
    dir_rows.push_back('{FN_GET, 24'd0, KIND_P, 1'b0, 64'd0, 4'd0, 1'b0, z});
    dir_rows.push_back('{FN_GET, 24'd0, KIND_P, 1'b0, 64'd0, 4'd0, 1'b0, z});
    dir_rows.push_back('{FN_RST, 24'd0, KIND_P, 1'b0, 64'd0, 4'd7, 1'b0, z});
    dir_rows.push_back('{FN_GET, 24'd0, KIND_P, 1'b0, 64'd0, 4'd7, 1'b0, z});
    dir_rows.push_back('{FN_PUT, 24'd1, KIND_I, 1'b0, 64'hAA, 4'd0, 1'b0, z});
    dir_rows.push_back('{FN_PUT, 24'd7, KIND_A, 1'b0, 64'hBB, 4'd0, 1'b0, z});
    dir_rows.push_back('{FN_GET, 24'd0, KIND_P, 1'b0, 64'd0, 4'd7, 1'b0, z});
    dir_rows.push_back('{FN_GET, 24'd0, KIND_P, 1'b0, 64'd0, 4'd3, 1'b0, z});
    dir_rows.push_back('{FN_GET, 24'd0, KIND_P, 1'b0, 64'd0, 4'd3, 1'b0, z});
    dir_rows.push_back('{FN_RST, 24'd0, KIND_P, 1'b0, 64'd0, 4'd9, 1'b1, bad});
    dir_rows.push_back('{FN_RST, 24'd0, KIND_P, 1'b0, 64'd0, 4'd7, 1'b0, z});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i]) send_req(dir_rows[i]);
    in_valid <= 1'b0;
    drain();

    // Smallest store: wraps on nearly every put.
    write_buf_size(32'd64);
    random_phase(32'd64, 50, 55);
    in_valid <= 1'b0;
    drain();

    // Mid-size store, sender without gaps.
    gaps_on = 1'b0;
    write_buf_size(32'd3000);
    random_phase(32'd3000, 60, 55);
    gaps_on = 1'b1;
    in_valid <= 1'b0;
    drain();

    // Largest store with small frames: only the slot table fills up and wraps.
    write_buf_size(32'hFFFFFFFF);
    random_phase(32'hFFFFFFFF, 1100, 96);
    in_valid <= 1'b0;
    drain();

    // Back to the reset value with a mixed load.
    write_buf_size(BufSizeReset);
    random_phase(BufSizeReset, 40, 45);
    in_valid <= 1'b0;
    drain();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver stalls: stall_cnt sets when a new pattern is chosen, from never
  // stalling through random to mostly stalled.
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    frame_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, status %0h", $time, status_q);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_q);
        check_field("start_pos", want.start, start_q);
        check_field("entry_len", want.elen, elen_q);
        check_field("stamp_out", want.stamp, stamp_q);
        check_field("kind_out", want.kind, kind_q);
        check_field("talk_out", want.talk, talk_q);
        check_field("key_offset", want.koff, koff_q);
        check_field("lag", want.lag, lag_q);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hdl/frim_pkg.sv
hdl/frim_ram.sv
hdl/frame_ring_index_multi_reader_core.sv
hdl/frim_checker.sv
tb/tb_top.sv
